// ===== hdl/obb_overlap_test_core_defines.svh =====
// Assertion macros shared by the box overlap test RTL.
`ifndef OBB_OVERLAP_TEST_CORE_DEFINES_SVH
`define OBB_OVERLAP_TEST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define OBB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("obb assertion failed");

// Next-cycle implication, disabled while reset is held.
`define OBB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("obb assertion failed");

`endif

// ===== hdl/obb_pkg.sv =====
// Package with widths, constants and the inter-stage record of the box overlap test.
`default_nettype none
package obb_pkg;
    localparam int COORD_W   = 20;
    localparam int ROT_W     = 16;
    localparam int FRAC      = 14;
    localparam int EPS_W     = 10;
    localparam int DIST_W    = 42;
    localparam int LATENCY   = 6;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(16);

    localparam int D_W    = COORD_W + 1;
    localparam int P_W    = D_W + ROT_W;
    localparam int T_W    = P_W + 2;
    localparam int S_W    = 2 * ROT_W + 2;
    localparam int R_W    = S_W - FRAC - 1;
    localparam int RM_W   = R_W - 1;
    localparam int AR_W   = ((RM_W > EPS_W) ? RM_W : EPS_W) + 1;
    localparam int Q_W    = COORD_W + AR_W;
    localparam int RAD_W  = Q_W + 2;
    localparam int TR_W   = T_W + R_W;
    localparam int L_W    = TR_W + 2;
    localparam int CMP_W  = ((L_W > RAD_W + FRAC) ? L_W : RAD_W + FRAC) + 1;
    localparam int SQ_W   = (2 * D_W + 2 > DIST_W) ? 2 * D_W + 2 : DIST_W;
    localparam logic [S_W:0] ROUND_HALF = (S_W + 1)'(1) << (FRAC - 1);

    // Relative rotation, offset in A's frame and extents after the front stages.
    typedef struct packed {
        logic                                vld;
        logic [2:0][2:0][R_W-1:0]            r;
        logic [2:0][2:0][AR_W-1:0]           ar;
        logic [2:0][T_W-1:0]                 t;
        logic [2:0][COORD_W-1:0]             ea;
        logic [2:0][COORD_W-1:0]             eb;
        logic [SQ_W-1:0]                     dsq;
    } t_rel;
endpackage
`default_nettype wire

// ===== hdl/obb_relrot.sv =====
// Front three stages: relative rotation, absolute rotation, offset and center distance.
`default_nettype none
module obb_relrot
    import obb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [59:0]        i_center_a,
    input  wire logic [59:0]        i_center_b,
    input  wire logic [59:0]        i_extents_a,
    input  wire logic [59:0]        i_extents_b,
    input  wire logic [47:0]        i_rot_a_row0,
    input  wire logic [47:0]        i_rot_a_row1,
    input  wire logic [47:0]        i_rot_a_row2,
    input  wire logic [47:0]        i_rot_b_row0,
    input  wire logic [47:0]        i_rot_b_row1,
    input  wire logic [47:0]        i_rot_b_row2,
    input  wire logic [EPS_W-1:0]   i_eps,
    output t_rel                    o_rel
);
    logic signed [COORD_W-1:0] ca [3];
    logic signed [COORD_W-1:0] cb [3];
    logic signed [ROT_W-1:0]   ra [3][3];
    logic signed [ROT_W-1:0]   rb [3][3];

    logic                       r1_vld;
    logic signed [D_W-1:0]      r1_d [3], n_d [3];
    logic signed [2*ROT_W-1:0]  r1_pr [3][3][3], n_pr [3][3][3];
    logic signed [P_W-1:0]      r1_pt [3][3], n_pt [3][3];
    logic [2:0][COORD_W-1:0]    r1_ea, r1_eb;

    logic                       r2_vld;
    logic signed [S_W-1:0]      r2_s [3][3], n_s [3][3];
    logic signed [T_W-1:0]      r2_t [3], n_t [3];
    logic signed [2*D_W-1:0]    r2_dsq [3], n_dsq [3];
    logic [2:0][COORD_W-1:0]    r2_ea, r2_eb;

    t_rel r3_rel, n_rel;
    logic [S_W-1:0]  mg  [3][3];
    logic [S_W:0]    rnd [3][3];
    logic [RM_W-1:0] rm  [3][3];

    always_comb begin
        logic [ROT_W*3-1:0] rowa [3];
        logic [ROT_W*3-1:0] rowb [3];
        rowa[0] = i_rot_a_row0[ROT_W*3-1:0];
        rowa[1] = i_rot_a_row1[ROT_W*3-1:0];
        rowa[2] = i_rot_a_row2[ROT_W*3-1:0];
        rowb[0] = i_rot_b_row0[ROT_W*3-1:0];
        rowb[1] = i_rot_b_row1[ROT_W*3-1:0];
        rowb[2] = i_rot_b_row2[ROT_W*3-1:0];
        for (int k = 0; k < 3; k++) begin
            ca[k] = $signed(i_center_a[k*COORD_W +: COORD_W]);
            cb[k] = $signed(i_center_b[k*COORD_W +: COORD_W]);
            for (int i = 0; i < 3; i++) begin
                ra[i][k] = $signed(rowa[i][k*ROT_W +: ROT_W]);
                rb[i][k] = $signed(rowb[i][k*ROT_W +: ROT_W]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_d[k] = D_W'(cb[k]) - D_W'(ca[k]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_pt[i][k] = P_W'(n_d[k]) * P_W'(ra[i][k]);
                for (int j = 0; j < 3; j++) begin
                    n_pr[i][j][k] = (2*ROT_W)'(ra[i][k]) * (2*ROT_W)'(rb[j][k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_d  <= n_d;
        r1_pr <= n_pr;
        r1_pt <= n_pt;
        for (int k = 0; k < 3; k++) begin
            r1_ea[k] <= i_extents_a[k*COORD_W +: COORD_W];
            r1_eb[k] <= i_extents_b[k*COORD_W +: COORD_W];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i] = T_W'(r1_pt[i][0]) + T_W'(r1_pt[i][1]) + T_W'(r1_pt[i][2]);
            n_dsq[i] = (2*D_W)'(r1_d[i]) * (2*D_W)'(r1_d[i]);
            for (int j = 0; j < 3; j++) begin
                n_s[i][j] = S_W'(r1_pr[i][j][0]) + S_W'(r1_pr[i][j][1])
                          + S_W'(r1_pr[i][j][2]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_s   <= n_s;
        r2_t   <= n_t;
        r2_dsq <= n_dsq;
        r2_ea  <= r1_ea;
        r2_eb  <= r1_eb;
    end

    // Round the magnitude half away from zero, then restore the sign.
    always_comb begin
        n_rel.vld = r2_vld;
        n_rel.ea  = r2_ea;
        n_rel.eb  = r2_eb;
        n_rel.dsq = SQ_W'($unsigned(r2_dsq[0])) + SQ_W'($unsigned(r2_dsq[1]))
                  + SQ_W'($unsigned(r2_dsq[2]));
        for (int i = 0; i < 3; i++) begin
            n_rel.t[i] = r2_t[i];
            for (int j = 0; j < 3; j++) begin
                mg[i][j]  = r2_s[i][j][S_W-1] ? $unsigned(-r2_s[i][j])
                                              : $unsigned(r2_s[i][j]);
                rnd[i][j] = (S_W + 1)'(mg[i][j]) + ROUND_HALF;
                rm[i][j]  = rnd[i][j][FRAC +: RM_W];
                n_rel.r[i][j] = r2_s[i][j][S_W-1] ? -R_W'(rm[i][j]) : R_W'(rm[i][j]);
                n_rel.ar[i][j] = AR_W'(rm[i][j]) + AR_W'(i_eps);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_rel.vld <= 1'b0;
        end else begin
            r3_rel.vld <= n_rel.vld;
        end
        r3_rel.r    <= n_rel.r;
        r3_rel.ar   <= n_rel.ar;
        r3_rel.t    <= n_rel.t;
        r3_rel.ea   <= n_rel.ea;
        r3_rel.eb   <= n_rel.eb;
        r3_rel.dsq  <= n_rel.dsq;
    end

    assign o_rel = r3_rel;
endmodule
`default_nettype wire

// ===== hdl/obb_overlap_test_core.sv =====
// Top level of the oriented box overlap test: 15-axis separating axis pipeline.
//
// Usage: drive the two boxes on the i_ ports and raise start; an item is taken
// at every rising edge with start high and busy low. busy is always low, so one
// box pair can be taken every cycle.
// Each item gives one result once it has passed the register stages: o_done is
// high for exactly one cycle with o_overlapping and o_center_distance_sq.
// The six register stages are: unpack and products, dot-product sums, rounding
// and absolute rotation, axis products, projection and radius sums, and the
// final compares. Throughput is one item per cycle, set by the fully pipelined
// multiplier array.
// The parallel epsilon register is written through i_cfg_valid / o_cfg_ready /
// i_cfg_data (ready is always high); write it only while no item is in flight.
// Reset (synchronous, active low) empties the pipeline and sets the epsilon to
// 16. The receiver has no way to stall: a result must be taken when o_done
// is high.
`default_nettype none
`include "obb_overlap_test_core_defines.svh"
module obb_overlap_test_core
    import obb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [59:0]        i_center_a,
    input  wire logic [59:0]        i_center_b,
    input  wire logic [59:0]        i_extents_a,
    input  wire logic [59:0]        i_extents_b,
    input  wire logic [47:0]        i_rot_a_row0,
    input  wire logic [47:0]        i_rot_a_row1,
    input  wire logic [47:0]        i_rot_a_row2,
    input  wire logic [47:0]        i_rot_b_row0,
    input  wire logic [47:0]        i_rot_b_row1,
    input  wire logic [47:0]        i_rot_b_row2,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [EPS_W-1:0]   i_cfg_data,
    output logic                    o_done,
    output logic                    o_overlapping,
    output logic [DIST_W-1:0]       o_center_distance_sq
);
    logic [EPS_W-1:0] r_eps;
    t_rel             rel;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_eps <= i_cfg_data;
        end
    end

    obb_relrot u_relrot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (start && !busy),
        .i_center_a   (i_center_a),
        .i_center_b   (i_center_b),
        .i_extents_a  (i_extents_a),
        .i_extents_b  (i_extents_b),
        .i_rot_a_row0 (i_rot_a_row0),
        .i_rot_a_row1 (i_rot_a_row1),
        .i_rot_a_row2 (i_rot_a_row2),
        .i_rot_b_row0 (i_rot_b_row0),
        .i_rot_b_row1 (i_rot_b_row1),
        .i_rot_b_row2 (i_rot_b_row2),
        .i_eps        (r_eps),
        .o_rel        (rel)
    );

    // Stage four: every product that a projection or a radius needs.
    logic                    r4_vld;
    logic signed [TR_W-1:0]  r4_pb [3][3], n_pb [3][3];
    logic signed [TR_W-1:0]  r4_pe1 [3][3], n_pe1 [3][3];
    logic signed [TR_W-1:0]  r4_pe2 [3][3], n_pe2 [3][3];
    logic [Q_W-1:0]          r4_fa [3][3], n_fa [3][3];
    logic [Q_W-1:0]          r4_fb [3][3], n_fb [3][3];
    logic [Q_W-1:0]          r4_eq [3][3][4], n_eq [3][3][4];
    logic [T_W-1:0]          r4_tabs [3], n_tabs [3];
    logic [2:0][COORD_W-1:0] r4_ea, r4_eb;
    logic [SQ_W-1:0]         r4_dist;

    always_comb begin
        int i1, i2, j1, j2;
        i1 = 0; i2 = 0; j1 = 0; j2 = 0;
        for (int i = 0; i < 3; i++) begin
            n_tabs[i] = rel.t[i][T_W-1] ? $unsigned(-$signed(rel.t[i])) : rel.t[i];
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                n_pb[i][j]  = TR_W'($signed(rel.t[i]))  * TR_W'($signed(rel.r[i][j]));
                n_pe1[i][j] = TR_W'($signed(rel.t[i2])) * TR_W'($signed(rel.r[i1][j]));
                n_pe2[i][j] = TR_W'($signed(rel.t[i1])) * TR_W'($signed(rel.r[i2][j]));
                n_fa[i][j]  = Q_W'(rel.eb[j]) * Q_W'(rel.ar[i][j]);
                n_fb[i][j]  = Q_W'(rel.ea[i]) * Q_W'(rel.ar[i][j]);
                n_eq[i][j][0] = Q_W'(rel.ea[i1]) * Q_W'(rel.ar[i2][j]);
                n_eq[i][j][1] = Q_W'(rel.ea[i2]) * Q_W'(rel.ar[i1][j]);
                n_eq[i][j][2] = Q_W'(rel.eb[j1]) * Q_W'(rel.ar[i][j2]);
                n_eq[i][j][3] = Q_W'(rel.eb[j2]) * Q_W'(rel.ar[i][j1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= rel.vld;
        end
        r4_pb   <= n_pb;
        r4_pe1  <= n_pe1;
        r4_pe2  <= n_pe2;
        r4_fa   <= n_fa;
        r4_fb   <= n_fb;
        r4_eq   <= n_eq;
        r4_tabs <= n_tabs;
        r4_ea   <= rel.ea;
        r4_eb   <= rel.eb;
        r4_dist <= rel.dsq;
    end

    // Stage five: projection magnitudes and radius sums.
    logic               r5_vld;
    logic [T_W-1:0]     r5_tabs [3];
    logic [RAD_W-1:0]   r5_farhs [3], n_farhs [3];
    logic [L_W-1:0]     r5_fbl [3], n_fbl [3];
    logic [RAD_W-1:0]   r5_fbr [3], n_fbr [3];
    logic [L_W-1:0]     r5_el [3][3], n_el [3][3];
    logic [RAD_W-1:0]   r5_er [3][3], n_er [3][3];
    logic [SQ_W-1:0]    r5_dist;
    logic signed [L_W-1:0] sl;

    always_comb begin
        sl = '0;
        for (int i = 0; i < 3; i++) begin
            n_farhs[i] = RAD_W'({r4_ea[i], {FRAC{1'b0}}}) + RAD_W'(r4_fa[i][0])
                       + RAD_W'(r4_fa[i][1]) + RAD_W'(r4_fa[i][2]);
        end
        for (int j = 0; j < 3; j++) begin
            sl = L_W'(r4_pb[0][j]) + L_W'(r4_pb[1][j]) + L_W'(r4_pb[2][j]);
            n_fbl[j] = sl[L_W-1] ? $unsigned(-sl) : $unsigned(sl);
            n_fbr[j] = RAD_W'(r4_fb[0][j]) + RAD_W'(r4_fb[1][j]) + RAD_W'(r4_fb[2][j])
                     + RAD_W'({r4_eb[j], {FRAC{1'b0}}});
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sl = L_W'(r4_pe1[i][j]) - L_W'(r4_pe2[i][j]);
                n_el[i][j] = sl[L_W-1] ? $unsigned(-sl) : $unsigned(sl);
                n_er[i][j] = RAD_W'(r4_eq[i][j][0]) + RAD_W'(r4_eq[i][j][1])
                           + RAD_W'(r4_eq[i][j][2]) + RAD_W'(r4_eq[i][j][3]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_tabs  <= r4_tabs;
        r5_farhs <= n_farhs;
        r5_fbl   <= n_fbl;
        r5_fbr   <= n_fbr;
        r5_el    <= n_el;
        r5_er    <= n_er;
        r5_dist  <= r4_dist;
    end

    // Stage six: a strict greater-than on any axis separates the boxes.
    logic n_sep;

    always_comb begin
        n_sep = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (CMP_W'(r5_tabs[i]) > CMP_W'(r5_farhs[i])) n_sep = 1'b1;
            if (CMP_W'(r5_fbl[i]) > CMP_W'({r5_fbr[i], {FRAC{1'b0}}})) n_sep = 1'b1;
            for (int j = 0; j < 3; j++) begin
                if (CMP_W'(r5_el[i][j]) > CMP_W'({r5_er[i][j], {FRAC{1'b0}}})) begin
                    n_sep = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r5_vld;
        end
        o_overlapping        <= !n_sep;
        o_center_distance_sq <= r5_dist[DIST_W-1:0];
    end

    `OBB_ASSERT_IMP(a_done_latency, o_done, $past(start && !busy, LATENCY))
    `OBB_ASSERT_IMP(a_front_align, o_done, $past(rel.vld, 3))
    `OBB_ASSERT_IMP(a_same_center, o_done && (o_center_distance_sq == '0), o_overlapping)
    `OBB_ASSERT_NXT(a_eps_write, i_cfg_valid && o_cfg_ready, r_eps == $past(i_cfg_data))
endmodule
`default_nettype wire

// ===== dv/obb_overlap_test_checker.sv =====
// Checker for the box overlap test: predicts each box pair's result and compares.
`default_nettype none
module obb_overlap_test_checker
    import obb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [59:0]        i_center_a,
    input  wire logic [59:0]        i_center_b,
    input  wire logic [59:0]        i_extents_a,
    input  wire logic [59:0]        i_extents_b,
    input  wire logic [47:0]        i_rot_a_row0,
    input  wire logic [47:0]        i_rot_a_row1,
    input  wire logic [47:0]        i_rot_a_row2,
    input  wire logic [47:0]        i_rot_b_row0,
    input  wire logic [47:0]        i_rot_b_row1,
    input  wire logic [47:0]        i_rot_b_row2,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [EPS_W-1:0]   i_cfg_data,
    input  wire logic               i_done,
    input  wire logic               i_overlapping,
    input  wire logic [DIST_W-1:0]  i_center_distance_sq,
    output int                      o_pending,
    output int                      o_fail_count
);
    localparam longint ONE_Q14 = 64'sd16384;

    typedef struct {
        logic              overlap;
        logic [DIST_W-1:0] dist_sq;
    } t_pair_result;

    t_pair_result     results_due[$];
    logic [EPS_W-1:0] eps_q14;
    int               fails = 0;

    function automatic longint abs64(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic t_pair_result sat_outcome(
        logic [59:0] ca_v, logic [59:0] cb_v, logic [59:0] ea_v, logic [59:0] eb_v,
        logic [2:0][47:0] ra_v, logic [2:0][47:0] rb_v, logic [EPS_W-1:0] eps);
        longint       ca[3], cb[3], ea[3], eb[3], ra[3][3], rb[3][3];
        longint       d[3], t[3], r[3][3], ar[3][3];
        longint       dsum, s, m, lhs, rhs;
        logic         sep;
        int           i1, i2, j1, j2;
        t_pair_result res;
        dsum = 0;
        sep  = 1'b0;
        for (int k = 0; k < 3; k++) begin
            ca[k] = longint'($signed(ca_v[k*COORD_W +: COORD_W]));
            cb[k] = longint'($signed(cb_v[k*COORD_W +: COORD_W]));
            ea[k] = longint'({1'b0, ea_v[k*COORD_W +: COORD_W]});
            eb[k] = longint'({1'b0, eb_v[k*COORD_W +: COORD_W]});
            for (int i = 0; i < 3; i++) begin
                ra[i][k] = longint'($signed(ra_v[i][k*ROT_W +: ROT_W]));
                rb[i][k] = longint'($signed(rb_v[i][k*ROT_W +: ROT_W]));
            end
        end
        for (int k = 0; k < 3; k++) begin
            d[k] = cb[k] - ca[k];
            dsum += d[k] * d[k];
        end
        for (int i = 0; i < 3; i++) begin
            t[i] = d[0] * ra[i][0] + d[1] * ra[i][1] + d[2] * ra[i][2];
            for (int j = 0; j < 3; j++) begin
                s = ra[i][0] * rb[j][0] + ra[i][1] * rb[j][1] + ra[i][2] * rb[j][2];
                // Round the magnitude half away from zero, then restore the sign.
                m = (abs64(s) + ONE_Q14 / 2) / ONE_Q14;
                r[i][j]  = (s < 0) ? -m : m;
                ar[i][j] = m + longint'({1'b0, eps});
            end
        end
        for (int i = 0; i < 3; i++) begin
            rhs = ea[i] * ONE_Q14 + eb[0] * ar[i][0] + eb[1] * ar[i][1] + eb[2] * ar[i][2];
            if (abs64(t[i]) > rhs) sep = 1'b1;
        end
        for (int j = 0; j < 3; j++) begin
            lhs = t[0] * r[0][j] + t[1] * r[1][j] + t[2] * r[2][j];
            rhs = ea[0] * ar[0][j] + ea[1] * ar[1][j] + ea[2] * ar[2][j] + eb[j] * ONE_Q14;
            if (abs64(lhs) > rhs * ONE_Q14) sep = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                rhs = ea[i1] * ar[i2][j] + ea[i2] * ar[i1][j]
                    + eb[j1] * ar[i][j2] + eb[j2] * ar[i][j1];
                lhs = t[i2] * r[i1][j] - t[i1] * r[i2][j];
                if (abs64(lhs) > rhs * ONE_Q14) sep = 1'b1;
            end
        end
        res.overlap = !sep;
        res.dist_sq = dsum[DIST_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pair_result want;
        t_pair_result fresh;
        if (!i_rst_n) begin
            eps_q14 <= EPS_RESET;
            results_due.delete();
            o_pending <= 0;
        end else begin
            if (start && !busy) begin
                fresh = sat_outcome(i_center_a, i_center_b, i_extents_a,
                    i_extents_b, {i_rot_a_row2, i_rot_a_row1, i_rot_a_row0},
                    {i_rot_b_row2, i_rot_b_row1, i_rot_b_row0}, eps_q14);
                results_due.insert(results_due.size(), fresh);
            end
            if (i_cfg_valid && i_cfg_ready)
                eps_q14 <= i_cfg_data;
            if (i_done) begin
                if (results_due.size() == 0) begin
                    $error("result with no item pending: overlapping %0b dist %0h",
                           i_overlapping, i_center_distance_sq);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    if (i_overlapping !== want.overlap) begin
                        $error("overlapping: expected %0b, got %0b",
                               want.overlap, i_overlapping);
                        fails++;
                    end
                    if (i_center_distance_sq !== want.dist_sq) begin
                        $error("center_distance_sq: expected %0h, got %0h",
                               want.dist_sq, i_center_distance_sq);
                        fails++;
                    end
                end
            end
            o_pending <= results_due.size();
        end
    end

    assign o_fail_count = fails;
endmodule
`default_nettype wire

// ===== dv/tb_obb_overlap_test_core.sv =====
// Testbench top for the box overlap test: stimulus, configuration phases and verdict.
`default_nettype none
module tb_obb_overlap_test_core;
    import obb_pkg::*;

    localparam int RANDOM_ITEMS = 1330;
    localparam int CYCLE_LIMIT  = 300000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [59:0]        center_a, center_b, extents_a, extents_b;
    logic [47:0]        rot_a0, rot_a1, rot_a2, rot_b0, rot_b1, rot_b2;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [EPS_W-1:0]   cfg_data;
    logic               done;
    logic               overlapping;
    logic [DIST_W-1:0]  dist_sq;
    int                 pending;
    int                 fail_count;
    int                 cycles = 0;

    obb_overlap_test_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_center_a(center_a), .i_center_b(center_b),
        .i_extents_a(extents_a), .i_extents_b(extents_b),
        .i_rot_a_row0(rot_a0), .i_rot_a_row1(rot_a1), .i_rot_a_row2(rot_a2),
        .i_rot_b_row0(rot_b0), .i_rot_b_row1(rot_b1), .i_rot_b_row2(rot_b2),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_done(done), .o_overlapping(overlapping), .o_center_distance_sq(dist_sq)
    );

    obb_overlap_test_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_center_a(center_a), .i_center_b(center_b),
        .i_extents_a(extents_a), .i_extents_b(extents_b),
        .i_rot_a_row0(rot_a0), .i_rot_a_row1(rot_a1), .i_rot_a_row2(rot_a2),
        .i_rot_b_row0(rot_b0), .i_rot_b_row1(rot_b1), .i_rot_b_row2(rot_b2),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_done(done), .i_overlapping(overlapping), .i_center_distance_sq(dist_sq),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [59:0] rand60();
        return 60'({$urandom(), $urandom()});
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Three signed coordinates around a base, each within +/- spread.
    function automatic logic [59:0] coords_near(int base[3], int spread);
        logic [59:0] v;
        for (int k = 0; k < 3; k++)
            v[k*COORD_W +: COORD_W] = COORD_W'(base[k] + $urandom_range(2 * spread) - spread);
        return v;
    endfunction

    function automatic logic [59:0] extents_upto(int top);
        logic [59:0] v;
        for (int k = 0; k < 3; k++)
            v[k*COORD_W +: COORD_W] = COORD_W'($urandom_range(top));
        return v;
    endfunction

    // Rotation as a signed permutation with unit entries, or loose entries in [-1, 1].
    task automatic pick_rotation(output logic [47:0] r0, output logic [47:0] r1,
                                 output logic [47:0] r2);
        logic [2:0][47:0] rows;
        int               perm[3];
        int               sw, tmp;
        rows = '0;
        perm = '{0, 1, 2};
        if ($urandom_range(1)) begin
            sw = $urandom_range(2);
            tmp = perm[0]; perm[0] = perm[sw]; perm[sw] = tmp;
            sw = 1 + $urandom_range(1);
            tmp = perm[1]; perm[1] = perm[sw]; perm[sw] = tmp;
            for (int i = 0; i < 3; i++)
                rows[i][perm[i]*ROT_W +: ROT_W] = $urandom_range(1) ? ROT_W'(16384)
                                                                   : ROT_W'(-16384);
        end else begin
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++)
                    rows[i][k*ROT_W +: ROT_W] = ROT_W'(int'($urandom_range(32768)) - 16384);
        end
        r0 = rows[0];
        r1 = rows[1];
        r2 = rows[2];
    endtask

    task automatic present_pair();
        logic took;
        start <= 1'b1;
        do begin
            @(negedge i_clk);
            took = !busy;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        idle_cycles(1);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] value);
        logic took;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(negedge i_clk);
            took = cfg_ready;
            @(posedge i_clk);
        end while (!took);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_pair();
        int base[3];
        logic [47:0] a0, a1, a2, b0, b1, b2;
        if ($urandom_range(9) < 3) begin
            center_a  <= rand60();
            center_b  <= rand60();
            extents_a <= rand60();
            extents_b <= rand60();
            rot_a0 <= rand48(); rot_a1 <= rand48(); rot_a2 <= rand48();
            rot_b0 <= rand48(); rot_b1 <= rand48(); rot_b2 <= rand48();
        end else begin
            // Boxes placed close together so both outcomes occur often.
            for (int k = 0; k < 3; k++) base[k] = int'($urandom_range(16384)) - 8192;
            center_a  <= coords_near(base, 256);
            center_b  <= coords_near(base, 4096);
            extents_a <= extents_upto($urandom_range(1) ? 2048 : 64);
            extents_b <= extents_upto($urandom_range(1) ? 2048 : 64);
            pick_rotation(a0, a1, a2);
            pick_rotation(b0, b1, b2);
            rot_a0 <= a0; rot_a1 <= a1; rot_a2 <= a2;
            rot_b0 <= b0; rot_b1 <= b1; rot_b2 <= b2;
        end
    endtask

    task automatic run_random(int count);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            for (int n = 0; n < burst && left > 0; n++) begin
                load_random_pair();
                present_pair();
                left--;
            end
            if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 8));
        end
    endtask

    task automatic load_directed(int idx);
        logic [59:0] ones60;
        logic [47:0] ident0, ident1, ident2;
        ones60 = '1;
        ident0 = 48'(16384);
        ident1 = 48'(16384) << ROT_W;
        ident2 = 48'(16384) << (2 * ROT_W);
        center_a <= '0; center_b <= '0; extents_a <= '0; extents_b <= '0;
        rot_a0 <= ident0; rot_a1 <= ident1; rot_a2 <= ident2;
        rot_b0 <= ident0; rot_b1 <= ident1; rot_b2 <= ident2;
        case (idx)
            0: ;                                    // two points at the origin
            1: begin                                // all fields at their maximum
                center_a <= ones60; center_b <= ones60;
                extents_a <= ones60; extents_b <= ones60;
                rot_a0 <= '1; rot_a1 <= '1; rot_a2 <= '1;
                rot_b0 <= '1; rot_b1 <= '1; rot_b2 <= '1;
            end
            2: begin                                // most negative vs most positive corner
                center_a <= {3{20'h80000}}; center_b <= {3{20'h7FFFF}};
            end
            3: begin
                center_a <= {3{20'h7FFFF}}; center_b <= {3{20'h80000}};
                extents_a <= ones60; extents_b <= ones60;
            end
            4: begin                                // touching faces do not separate
                center_b <= 60'(512); extents_a <= 60'(256); extents_b <= 60'(256);
            end
            5: begin                                // just apart on x
                center_b <= 60'(513); extents_a <= 60'(256); extents_b <= 60'(256);
            end
            6: begin                                // point inside a box
                center_b <= 60'(100); extents_a <= {3{20'd256}};
            end
            7: begin                                // zero rows: degenerate rotation
                rot_a0 <= '0; rot_a1 <= '0; rot_a2 <= '0;
                center_b <= 60'(1000); extents_a <= {3{20'd300}};
            end
            8: begin                                // rotation entries at signed extremes
                rot_a0 <= {3{16'h8000}}; rot_b1 <= {3{16'h7FFF}};
                center_b <= {20'd50, 20'd40, 20'd30}; extents_a <= {3{20'd20}};
            end
            9: begin                                // swapped axes, separated on an edge axis
                rot_b0 <= ident1; rot_b1 <= ident2; rot_b2 <= ident0;
                center_b <= {20'd600, 20'd600, 20'd0};
                extents_a <= {3{20'd256}}; extents_b <= {3{20'd256}};
            end
            10: begin                               // segment against a box
                extents_a <= 60'(2048); extents_b <= {3{20'd100}};
                center_b <= {20'd0, 20'd50, 20'd1500};
            end
            default: begin
                center_a <= rand60(); center_b <= rand60();
                extents_a <= rand60(); extents_b <= rand60();
                rot_a0 <= rand48(); rot_a1 <= rand48(); rot_a2 <= rand48();
                rot_b0 <= rand48(); rot_b1 <= rand48(); rot_b2 <= rand48();
            end
        endcase
    endtask

    initial begin
        logic [EPS_W-1:0] eps_plan[4];
        i_rst_n   = 1'b0;
        start     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        center_a = '0; center_b = '0; extents_a = '0; extents_b = '0;
        rot_a0 = '0; rot_a1 = '0; rot_a2 = '0;
        rot_b0 = '0; rot_b1 = '0; rot_b2 = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs run at the reset epsilon, then with the epsilon at zero.
        for (int i = 0; i < 14; i++) begin
            load_directed(i);
            present_pair();
        end
        drain();
        write_epsilon('0);
        for (int i = 0; i < 11; i++) begin
            load_directed(i);
            present_pair();
        end
        drain();

        eps_plan = '{10'd1023, 10'd16, EPS_W'($urandom()), 10'd0};
        for (int p = 0; p < 4; p++) begin
            write_epsilon(eps_plan[p]);
            run_random(RANDOM_ITEMS / 4);
            drain();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== obb_overlap_test_core.f =====
+incdir+hdl
hdl/obb_pkg.sv
hdl/obb_relrot.sv
hdl/obb_overlap_test_core.sv
dv/obb_overlap_test_checker.sv
dv/tb_obb_overlap_test_core.sv
